[design/ucjk_pkg.sv]
// Package for the UTF-8 CJK table converter: operation and mode codes, sizes, types.
// No dependencies.
`default_nettype none
package ucjk_pkg;
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] CJK_BASE = 16'h3400;

    typedef enum logic [1:0] {
        OP_TEXT  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_ORIG = 2'd0,
        MODE_T2S  = 2'd1,
        MODE_S2T  = 2'd2,
        MODE_S2T3 = 2'd3
    } mode_t;

    // Work handed from front to back: up to three bytes to emit, optionally a lookup.
    typedef struct packed {
        logic [1:0]  nbytes;     // raw bytes to emit, 0..3
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic        lookup;     // replace the three bytes on a table hit
        logic        tsel;       // 1: trad_to_simp table
        logic [15:0] cp;
        logic        eot;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_WAIT,
        BK_EMIT
    } bk_state_t;
endpackage
`default_nettype wire

[design/ucjk_if.sv]
// Valid/ready channel interfaces for the converter's input, output and config ports.
// Depends on nothing.
`default_nettype none
interface ucjk_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic        table_select;
    logic [7:0]  text_byte;
    logic        end_of_text;
    logic [15:0] source_code;
    logic [15:0] target_code;
    modport source (output valid, operation, table_select, text_byte, end_of_text,
                    source_code, target_code, input ready);
    modport sink (input valid, operation, table_select, text_byte, end_of_text,
                  source_code, target_code, output ready);
endinterface

interface ucjk_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_last;
    modport source (output valid, out_byte, run_last, text_last, input ready);
    modport sink (input valid, out_byte, run_last, text_last, output ready);
endinterface

interface ucjk_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[design/ucjk_front.sv]
// Front end: accepts items, tracks UTF-8 sequence state, updates table counts, emits jobs.
// Depends on ucjk_pkg.
`default_nettype none
module ucjk_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    ucjk_in_if.sink                   in_ch,
    input  wire logic [1:0]           mode,
    output      ucjk_pkg::job_t       job,
    output      logic                 job_valid,
    input  wire logic                 job_ready,
    input  wire logic                 back_empty,
    output      logic                 wr_en,
    output      logic                 wr_tsel,
    output      logic [ucjk_pkg::ADDR_W-1:0] wr_addr,
    output      logic [31:0]          wr_data,
    output      logic [ucjk_pkg::CNT_W-1:0]  s2t_cnt,
    output      logic [ucjk_pkg::CNT_W-1:0]  t2s_cnt
);
    import ucjk_pkg::*;

    logic [CNT_W-1:0] s2t_cnt_reg, s2t_cnt_next, t2s_cnt_reg, t2s_cnt_next;
    logic [15:0] pend_reg, pend_next;
    logic [1:0]  pcnt_reg, pcnt_next;
    logic [1:0]  skip_reg, skip_next;
    logic        acc;
    job_t        j;
    logic [7:0]  b;
    logic [15:0] cp;

    // table updates wait until no queued job can still search the tables
    assign in_ch.ready = (op_t'(in_ch.operation) == OP_TEXT) ? job_ready : back_empty;
    assign acc = in_ch.valid && in_ch.ready;
    assign b   = in_ch.text_byte;
    assign cp  = {pend_reg[3:0], pend_reg[13:8], b[5:0]};

    always_comb
    begin
        s2t_cnt_next = s2t_cnt_reg;
        t2s_cnt_next = t2s_cnt_reg;
        pend_next = pend_reg;
        pcnt_next = pcnt_reg;
        skip_next = skip_reg;
        wr_en = 1'b0;
        wr_tsel = in_ch.table_select;
        wr_addr = in_ch.table_select ? t2s_cnt_reg[ADDR_W-1:0] : s2t_cnt_reg[ADDR_W-1:0];
        wr_data = {in_ch.source_code, in_ch.target_code};
        j = '0;
        j.eot = in_ch.end_of_text;
        j.cp = cp;
        j.tsel = (mode == MODE_T2S);
        job_valid = 1'b0;
        unique case (op_t'(in_ch.operation))
            OP_LOAD:
            begin
                if (in_ch.table_select) begin
                    if (t2s_cnt_reg < CNT_W'(TABLE_DEPTH)) begin
                        wr_en = acc;
                        t2s_cnt_next = t2s_cnt_reg + 1'b1;
                    end
                end else if (s2t_cnt_reg < CNT_W'(TABLE_DEPTH)) begin
                    wr_en = acc;
                    s2t_cnt_next = s2t_cnt_reg + 1'b1;
                end
            end
            OP_CLEAR:
            begin
                s2t_cnt_next = '0;
                t2s_cnt_next = '0;
            end
            OP_NONE: ;
            OP_TEXT:
            begin
                job_valid = in_ch.valid;
                if (mode_t'(mode) == MODE_ORIG) begin
                    j.nbytes = pcnt_reg + 2'd1;
                    unique case (pcnt_reg)
                        2'd0: j.b0 = b;
                        2'd1: begin j.b0 = pend_reg[7:0]; j.b1 = b; end
                        default: begin j.b0 = pend_reg[7:0]; j.b1 = pend_reg[15:8]; j.b2 = b; end
                    endcase
                    pcnt_next = '0;
                    pend_next = '0;
                    skip_next = '0;
                end else if (skip_reg != 2'd0) begin
                    j.nbytes = 2'd1;
                    j.b0 = b;
                    skip_next = skip_reg - 2'd1;
                end else if (pcnt_reg == 2'd1) begin
                    pend_next = {b, pend_reg[7:0]};
                    pcnt_next = 2'd2;
                end else if (pcnt_reg == 2'd2) begin
                    j.nbytes = 2'd3;
                    j.b0 = pend_reg[7:0];
                    j.b1 = pend_reg[15:8];
                    j.b2 = b;
                    j.lookup = (cp >= CJK_BASE);
                    pcnt_next = '0;
                    pend_next = '0;
                end else if (b < 8'h80) begin
                    j.nbytes = 2'd1; j.b0 = b;
                end else if (b < 8'hE0) begin
                    j.nbytes = 2'd1; j.b0 = b; skip_next = 2'd1;
                end else if (b < 8'hF0) begin
                    pend_next = {8'h00, b}; pcnt_next = 2'd1;
                end else begin
                    j.nbytes = 2'd1; j.b0 = b; skip_next = 2'd3;
                end
                if (in_ch.end_of_text) begin
                    // cut-short sequence flushes raw; it is only held when nothing else emitted
                    if (pcnt_next != 2'd0) begin
                        j.nbytes = pcnt_next;
                        j.b0 = pend_next[7:0];
                        j.b1 = pend_next[15:8];
                    end
                    pcnt_next = '0;
                    pend_next = '0;
                    skip_next = '0;
                end
            end
            default: ;
        endcase
    end

    assign job = j;
    assign s2t_cnt = s2t_cnt_reg;
    assign t2s_cnt = t2s_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s2t_cnt_reg <= '0;
            t2s_cnt_reg <= '0;
            pend_reg <= '0;
            pcnt_reg <= '0;
            skip_reg <= '0;
        end else if (acc) begin
            s2t_cnt_reg <= s2t_cnt_next;
            t2s_cnt_reg <= t2s_cnt_next;
            pend_reg <= pend_next;
            pcnt_reg <= pcnt_next;
            skip_reg <= skip_next;
        end
    end
endmodule
`default_nettype wire

[design/ucjk_queue.sv]
// Short job queue between front and back ends.
// Depends on ucjk_pkg.
`default_nettype none
module ucjk_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ucjk_pkg::job_t wjob,
    input  wire logic           wvalid,
    output      logic           wready,
    output      ucjk_pkg::job_t rjob,
    output      logic           rvalid,
    input  wire logic           rready
);
    import ucjk_pkg::*;
    localparam int PW = $clog2(QUEUE_DEPTH);

    job_t mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    logic          push, pop;

    assign wready = (cnt_reg != (PW+1)'(QUEUE_DEPTH));
    assign rvalid = (cnt_reg != '0);
    assign push = wvalid && wready;
    assign pop = rvalid && rready;
    assign rjob = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= wjob;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

[design/ucjk_back.sv]
// Back end: table memories, binary search per lookup, byte emission with output register.
// Depends on ucjk_pkg.
`default_nettype none
module ucjk_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ucjk_pkg::job_t jb,
    input  wire logic           jvalid,
    output      logic           jready,
    input  wire logic           wr_en,
    input  wire logic           wr_tsel,
    input  wire logic [ucjk_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [31:0]    wr_data,
    input  wire logic [ucjk_pkg::CNT_W-1:0]  s2t_cnt,
    input  wire logic [ucjk_pkg::CNT_W-1:0]  t2s_cnt,
    ucjk_out_if.source          out_ch
);
    import ucjk_pkg::*;

    logic [31:0] s2t_mem [TABLE_DEPTH];
    logic [31:0] t2s_mem [TABLE_DEPTH];
    logic [31:0] s2t_q, t2s_q, e;

    bk_state_t st_reg, st_next;
    // signed bounds one bit wider than the count
    logic signed [CNT_W:0] lo_reg, lo_next, hi_reg, hi_next, mid;
    logic [15:0] res_reg, res_next;
    logic [1:0]  idx_reg, idx_next;
    logic        ov_reg;
    logic [7:0]  ob_reg;
    logic        orl_reg, otl_reg;
    logic        out_free, emit;
    logic [1:0]  nb;
    logic [7:0]  byte_sel;
    logic [ADDR_W-1:0] raddr;
    logic        hit;

    assign mid = (lo_reg + hi_reg) >>> 1;
    assign raddr = mid[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_tsel) s2t_mem[wr_addr] <= wr_data;
        if (wr_en && wr_tsel) t2s_mem[wr_addr] <= wr_data;
        s2t_q <= s2t_mem[raddr];
        t2s_q <= t2s_mem[raddr];
    end
    assign e = jb.tsel ? t2s_q : s2t_q;

    assign out_free = !ov_reg || out_ch.ready;
    assign hit = jb.lookup && (res_reg != jb.cp);
    assign nb = jb.nbytes;

    always_comb
    begin
        unique case (idx_reg)
            2'd0: byte_sel = hit ? {4'hE, res_reg[15:12]} : jb.b0;
            2'd1: byte_sel = hit ? {2'b10, res_reg[11:6]} : jb.b1;
            default: byte_sel = hit ? {2'b10, res_reg[5:0]} : jb.b2;
        endcase
    end

    always_comb
    begin
        st_next = st_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        res_next = res_reg;
        idx_next = idx_reg;
        unique case (st_reg)
            BK_IDLE:
            begin
                if (jvalid) begin
                    res_next = jb.cp;
                    idx_next = '0;
                    lo_next = '0;
                    hi_next = $signed({1'b0, jb.tsel ? t2s_cnt : s2t_cnt})
                              - (CNT_W+1)'(1);
                    if (jb.lookup) st_next = BK_SEARCH;
                    else if (nb != 2'd0) st_next = BK_EMIT;
                end
            end
            BK_SEARCH:
            begin
                if (lo_reg > hi_reg) st_next = BK_EMIT;
                else st_next = BK_WAIT;
            end
            BK_WAIT:
            begin
                st_next = BK_SEARCH;
                if (e[31:16] == jb.cp) begin
                    res_next = e[15:0];
                    st_next = BK_EMIT;
                end else if (e[31:16] < jb.cp) lo_next = mid + (CNT_W+1)'(1);
                else hi_next = mid - (CNT_W+1)'(1);
            end
            BK_EMIT:
            begin
                if (out_free) begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg + 2'd1 == nb) st_next = BK_IDLE;
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        emit = (st_reg == BK_EMIT) && out_free;
        jready = ((st_reg == BK_IDLE) && jvalid && !jb.lookup && (nb == 2'd0))
              || (emit && (idx_reg + 2'd1 == nb));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= BK_IDLE;
            ov_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (emit) ov_reg <= 1'b1;
            else if (out_ch.ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        res_reg <= res_next;
        idx_reg <= idx_next;
        if (emit) begin
            ob_reg <= byte_sel;
            orl_reg <= (idx_reg + 2'd1 == nb);
            otl_reg <= (idx_reg + 2'd1 == nb) && jb.eot;
        end
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.out_byte = ob_reg;
    assign out_ch.run_last = orl_reg;
    assign out_ch.text_last = otl_reg;
endmodule
`default_nettype wire

[design/utf8_cjk_table_converter.sv]
// UTF-8 CJK table converter top level: front end, job queue, back end.
// Text byte items pass through the front into the job queue; the back picks up a job,
// runs a binary search of up to 13 probes (read, then compare) for a lookup, and emits
// its bytes through the output register. The front can take further items while the
// back is busy, until the queue is full. Load and clear items wait for an empty queue.
// Reset (rst_n, async low) clears counts, sequence state, mode and queue; tables undefined.
`default_nettype none
module utf8_cjk_table_converter (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ucjk_in_if.sink    in_ch,
    ucjk_cfg_if.sink   cfg,
    ucjk_out_if.source out_ch
);
    import ucjk_pkg::*;

    logic [1:0] mode_reg;
    job_t fjob, qjob;
    logic fvalid, fready, qvalid, qready;
    logic back_empty;
    logic wr_en, wr_tsel;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0] wr_data;
    logic [CNT_W-1:0] s2t_cnt, t2s_cnt;

    // the back end pops a job only when it is done with it
    assign back_empty = !qvalid;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) mode_reg <= MODE_ORIG;
        else if (cfg.valid) mode_reg <= cfg.data;
    end

    ucjk_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .mode(mode_reg),
        .job(fjob), .job_valid(fvalid), .job_ready(fready), .back_empty(back_empty),
        .wr_en(wr_en), .wr_tsel(wr_tsel), .wr_addr(wr_addr), .wr_data(wr_data),
        .s2t_cnt(s2t_cnt), .t2s_cnt(t2s_cnt)
    );

    ucjk_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wjob(fjob), .wvalid(fvalid), .wready(fready),
        .rjob(qjob), .rvalid(qvalid), .rready(qready)
    );

    ucjk_back u_back (
        .clk(clk), .rst_n(rst_n), .jb(qjob), .jvalid(qvalid), .jready(qready),
        .wr_en(wr_en), .wr_tsel(wr_tsel), .wr_addr(wr_addr), .wr_data(wr_data),
        .s2t_cnt(s2t_cnt), .t2s_cnt(t2s_cnt), .out_ch(out_ch)
    );
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Testbench for utf8_cjk_table_converter: random and directed text, load and clear items.
// Depends on ucjk_pkg and the ucjk_*_if interfaces; predicts output bytes in SV.
`timescale 1ns / 1ps
module tb_top;
    import ucjk_pkg::*;

    typedef struct {
        op_t         op;
        logic        sel;
        logic [7:0]  b;
        logic        eot;
        logic [15:0] src;
        logic [15:0] dst;
    } text_item_t;

    typedef struct {
        logic [7:0] ob;
        logic       rl;
        logic       tl;
    } out_byte_t;

    logic clk;
    logic rst_n;
    ucjk_in_if  in_ch();
    ucjk_cfg_if cfg();
    ucjk_out_if out_ch();

    utf8_cjk_table_converter dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg(cfg), .out_ch(out_ch)
    );

    text_item_t pending_items[$];
    out_byte_t  expected_bytes[$];
    int         errors = 0;
    int         cycles = 0;
    int         bytes_seen = 0;
    int         items_sent = 0;

    // predictor state
    logic [31:0] s2t_tab[TABLE_DEPTH];
    logic [31:0] t2s_tab[TABLE_DEPTH];
    int          s2t_cnt = 0;
    int          t2s_cnt = 0;
    logic [7:0]  held_lead, held_second;
    int          held_cnt = 0;
    int          skip_left = 0;
    mode_t       cur_mode = MODE_ORIG;

    function automatic logic [15:0] table_lookup(bit t2s, logic [15:0] cp);
        int lo, hi, mid;
        logic [31:0] e;
        lo = 0;
        hi = (t2s ? t2s_cnt : s2t_cnt) - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            e = t2s ? t2s_tab[mid] : s2t_tab[mid];
            if (e[31:16] == cp) return e[15:0];
            if (e[31:16] < cp) lo = mid + 1;
            else hi = mid - 1;
        end
        return cp;
    endfunction

    task automatic predict_item(text_item_t it);
        logic [7:0] buf_q[$];
        logic [15:0] cp, mapped;
        out_byte_t o;
        if (it.op == OP_LOAD) begin
            if (it.sel == 1'b0) begin
                if (s2t_cnt < TABLE_DEPTH) begin
                    s2t_tab[s2t_cnt] = {it.src, it.dst};
                    s2t_cnt++;
                end
            end else if (t2s_cnt < TABLE_DEPTH) begin
                t2s_tab[t2s_cnt] = {it.src, it.dst};
                t2s_cnt++;
            end
            return;
        end
        if (it.op == OP_CLEAR) begin
            s2t_cnt = 0;
            t2s_cnt = 0;
            return;
        end
        if (it.op != OP_TEXT) return;
        if (cur_mode == MODE_ORIG) begin
            if (held_cnt >= 1) buf_q.push_back(held_lead);
            if (held_cnt >= 2) buf_q.push_back(held_second);
            held_cnt = 0;
            buf_q.push_back(it.b);
            skip_left = 0;
        end else if (skip_left > 0) begin
            buf_q.push_back(it.b);
            skip_left--;
        end else if (held_cnt == 1) begin
            held_second = it.b;
            held_cnt = 2;
        end else if (held_cnt == 2) begin
            cp = {held_lead[3:0], held_second[5:0], it.b[5:0]};
            mapped = cp;
            if (cp >= CJK_BASE) mapped = table_lookup(cur_mode == MODE_T2S, cp);
            if (mapped != cp) begin
                buf_q.push_back({4'hE, mapped[15:12]});
                buf_q.push_back({2'b10, mapped[11:6]});
                buf_q.push_back({2'b10, mapped[5:0]});
            end else begin
                buf_q.push_back(held_lead);
                buf_q.push_back(held_second);
                buf_q.push_back(it.b);
            end
            held_cnt = 0;
        end else if (it.b < 8'h80) begin
            buf_q.push_back(it.b);
        end else if (it.b < 8'hE0) begin
            buf_q.push_back(it.b);
            skip_left = 1;
        end else if (it.b < 8'hF0) begin
            held_lead = it.b;
            held_cnt = 1;
        end else begin
            buf_q.push_back(it.b);
            skip_left = 3;
        end
        if (it.eot) begin
            if (held_cnt >= 1) buf_q.push_back(held_lead);
            if (held_cnt >= 2) buf_q.push_back(held_second);
            held_cnt = 0;
            skip_left = 0;
        end
        foreach (buf_q[i]) begin
            o.ob = buf_q[i];
            o.rl = (i == buf_q.size() - 1);
            o.tl = o.rl && it.eot;
            expected_bytes.push_back(o);
        end
    endtask

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // input driver
    int in_gap = 0;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_item(pending_items.pop_front());
                items_sent++;
                in_gap = $urandom_range(0, 7);
                if ($urandom_range(0, 3) == 0) in_gap = 0;
            end
            if (in_gap > 0) begin
                in_gap--;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                in_ch.valid        <= 1'b1;
                in_ch.operation    <= pending_items[0].op;
                in_ch.table_select <= pending_items[0].sel;
                in_ch.text_byte    <= pending_items[0].b;
                in_ch.end_of_text  <= pending_items[0].eot;
                in_ch.source_code  <= pending_items[0].src;
                in_ch.target_code  <= pending_items[0].dst;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // output monitor
    int out_gap = 0;
    always @(posedge clk or negedge rst_n) begin
        out_byte_t exp_b;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            out_gap = 0;
        end else begin
            cycles++;
            if (out_ch.valid && out_ch.ready) begin
                bytes_seen++;
                if (expected_bytes.size() == 0) begin
                    $error("unexpected out_byte %h", out_ch.out_byte);
                    errors++;
                end else begin
                    exp_b = expected_bytes.pop_front();
                    if (out_ch.out_byte !== exp_b.ob) begin
                        $error("out_byte expected %h got %h", exp_b.ob, out_ch.out_byte);
                        errors++;
                    end
                    if (out_ch.run_last !== exp_b.rl) begin
                        $error("run_last expected %b got %b", exp_b.rl, out_ch.run_last);
                        errors++;
                    end
                    if (out_ch.text_last !== exp_b.tl) begin
                        $error("text_last expected %b got %b", exp_b.tl, out_ch.text_last);
                        errors++;
                    end
                end
                out_gap = $urandom_range(0, 7);
                if ($urandom_range(0, 3) == 0) out_gap = 0;
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic text_item_t mk_text(logic [7:0] b, logic eot);
        text_item_t it;
        it.op = OP_TEXT;
        it.sel = 1'($urandom_range(0, 1));
        it.b = b;
        it.eot = eot;
        it.src = 16'($urandom);
        it.dst = 16'($urandom);
        return it;
    endfunction

    function automatic text_item_t mk_load(logic sel, logic [15:0] src, logic [15:0] dst);
        text_item_t it;
        it.op = OP_LOAD;
        it.sel = sel;
        it.b = 8'($urandom);
        it.eot = 1'($urandom_range(0, 1));
        it.src = src;
        it.dst = dst;
        return it;
    endfunction

    function automatic text_item_t mk_ctl(op_t op);
        text_item_t it;
        it = mk_load(1'b0, 16'h0, 16'h0);
        it.op = op;
        it.src = 16'($urandom);
        it.dst = 16'($urandom);
        return it;
    endfunction

    // push a 3-byte char encoding cp
    task automatic push_char(logic [15:0] cp, logic eot);
        pending_items.push_back(mk_text({4'hE, cp[15:12]}, 1'b0));
        pending_items.push_back(mk_text({2'b10, cp[11:6]}, 1'b0));
        pending_items.push_back(mk_text({2'b10, cp[5:0]}, eot));
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || expected_bytes.size() > 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_mode(mode_t m);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= m;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        cur_mode = m;
    endtask

    // cps chosen from the small key set so random text hits the tables
    logic [15:0] keys[8];
    int n_char;

    initial begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_TEXT;
        in_ch.table_select = 1'b0;
        in_ch.text_byte = 8'h0;
        in_ch.end_of_text = 1'b0;
        in_ch.source_code = 16'h0;
        in_ch.target_code = 16'h0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = MODE_ORIG;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed, original mode: a lead byte at end of text passed raw, extremes of bytes
        pending_items.push_back(mk_text(8'h00, 1'b0));
        pending_items.push_back(mk_text(8'hFF, 1'b0));
        pending_items.push_back(mk_text(8'hE4, 1'b1));
        for (int i = 0; i < 8; i++) keys[i] = 16'h3400 + 16'(i * 16'h1111);
        for (int i = 0; i < 8; i++) begin
            pending_items.push_back(mk_load(1'b0, keys[i], 16'h4E00 + 16'(i)));
            pending_items.push_back(mk_load(1'b1, keys[i], 16'hFFFF - 16'(i)));
        end
        pending_items.push_back(mk_ctl(OP_NONE));
        wait_idle();

        set_mode(MODE_S2T);
        push_char(keys[3], 1'b0);       // hit
        push_char(16'h33FF, 1'b0);      // below CJK range
        pending_items.push_back(mk_text(8'hC3, 1'b0));   // 2-byte lead skips one
        pending_items.push_back(mk_text(8'hE8, 1'b0));
        pending_items.push_back(mk_text(8'hF0, 1'b0));   // 4-byte lead
        pending_items.push_back(mk_text(8'h80, 1'b0));
        pending_items.push_back(mk_text(8'hBF, 1'b0));
        pending_items.push_back(mk_text(8'h7F, 1'b0));
        pending_items.push_back(mk_text(8'hEF, 1'b0));
        pending_items.push_back(mk_text(8'hBF, 1'b1));   // cut short by end
        wait_idle();

        set_mode(MODE_T2S);
        push_char(keys[7], 1'b1);
        pending_items.push_back(mk_ctl(OP_CLEAR));
        push_char(keys[7], 1'b1);       // empty table: raw
        wait_idle();

        // random phases
        for (int ph = 0; ph < 2; ph++) begin
            mode_t m;
            m = mode_t'(ph == 0 ? MODE_S2T3 : $urandom_range(0, 3));
            set_mode(m);
            pending_items.push_back(mk_ctl(OP_CLEAR));
            for (int i = 0; i < 8; i++) begin
                keys[i] = 16'h3400 + 16'(i * 16'h1800) + 16'($urandom_range(0, 16'h17FF));
                pending_items.push_back(mk_load(1'b0, keys[i], 16'($urandom)));
                pending_items.push_back(mk_load(1'b1, keys[i], 16'($urandom)));
            end
            n_char = 0;
            while (n_char < 18) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        push_char($urandom_range(0, 9) < 7 ? keys[$urandom_range(0, 7)]
                                  : 16'($urandom), $urandom_range(0, 7) == 0);
                        n_char += 3;
                    end
                    4, 5: begin
                        pending_items.push_back(mk_text(8'($urandom),
                                                        $urandom_range(0, 5) == 0));
                        n_char++;
                    end
                    6: begin
                        pending_items.push_back(mk_text(8'($urandom_range(0, 127)), 1'b0));
                        n_char++;
                    end
                    7: pending_items.push_back(mk_ctl(OP_NONE));
                    8: pending_items.push_back(mk_load(1'($urandom_range(0, 1)), 16'hFFFF,
                                                       16'($urandom)));
                    default: begin
                        pending_items.push_back(mk_text(8'hE0 | 8'($urandom_range(0, 15)),
                                                        1'b0));
                        pending_items.push_back(mk_text(8'($urandom), 1'b1));
                        n_char += 2;
                    end
                endcase
            end
            wait_idle();
        end
        set_mode(MODE_ORIG);
        pending_items.push_back(mk_text(8'hE5, 1'b0));
        pending_items.push_back(mk_text(8'h9B, 1'b0));
        pending_items.push_back(mk_text(8'h41, 1'b1));
        wait_idle();

        $display("Covered %0d input items and %0d output bytes across all four modes,",
                 items_sent, bytes_seen);
        $display("with table loads, clears, no-op items and truncated sequences.");
        if (errors == 0)
            $display("[utf8_cjk_table_converter] OK");
        else
            $display("[utf8_cjk_table_converter] ERROR");
        $finish;
    end

    initial begin
        wait (cycles >= 400000);
        $display("[utf8_cjk_table_converter] ERROR");
        $finish;
    end
endmodule

[utf8_cjk_table_converter.f]
design/ucjk_pkg.sv
design/ucjk_if.sv
design/ucjk_front.sv
design/ucjk_queue.sv
design/ucjk_back.sv
design/utf8_cjk_table_converter.sv
tb/tb_top.sv
